/* sv/fplc_pkg.sv */
// ----------------------------------------------------------------------------
// fplc_pkg
// Shared types, constants and functions of the firmware packet loader.
// ----------------------------------------------------------------------------
package fplc_pkg;

	// Packet size limit and field widths
	localparam int MAX_PACKET_DEF = 64;
	localparam int LEN_W          = 7;

	// Queue depths
	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// Configuration register indexes
	localparam logic REG_HEADER_BASE = 1'b0;
	localparam logic REG_FLASH_LIMIT = 1'b1;

	// Register reset values and payload offset
	localparam logic [31:0] HEADER_BASE_RST = 32'h0800_4000;
	localparam logic [31:0] FLASH_LIMIT_RST = 32'h0808_0000;
	localparam logic [31:0] PAYLOAD_OFFSET  = 32'd20;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_HEADER   = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW = 2'd2;

	// CRC-32 and header constants
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] HDR_MAGIC     = 32'hDEAD_BEEF;
	localparam logic [31:0] HDR_VERSION   = 32'd1;
	localparam logic [31:0] HDR_STATE_OK  = 32'h1234_5678;
	localparam logic [2:0]  HDR_LAST_WORD = 3'd4;

	// Command from parser to executor
	typedef struct packed {
		logic             hdr;
		logic [LEN_W-1:0] len;
	} cmd_t;

	// Packet buffer write request
	typedef struct packed {
		logic             we;
		logic             bank;
		logic [LEN_W-1:0] idx;
		logic [7:0]       data;
	} buf_wr_t;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [31:0] value;
		logic        last;
	} result_t;

	// Fold one byte into a reflected CRC-32
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// Image header word by position
	function automatic logic [31:0] hdr_word(input logic [2:0] i, input logic [31:0] size,
			input logic [31:0] crc);
		logic [31:0] w;
		case (i)
			3'd0:    w = HDR_MAGIC;
			3'd1:    w = size;
			3'd2:    w = crc ^ CRC_INIT;
			3'd3:    w = HDR_VERSION;
			default: w = HDR_STATE_OK;
		endcase
		return w;
	endfunction

endpackage

/* sv/fplc_fifo.sv */
// ----------------------------------------------------------------------------
// fplc_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module fplc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/fplc_front.sv */
// ----------------------------------------------------------------------------
// fplc_front
// Packet parser: frames length, payload and checksum bytes, fills the
// packet buffer bank and issues packet and header commands.
// ----------------------------------------------------------------------------
module fplc_front import fplc_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	output logic       full,
	input  logic       cmd_full,
	input  logic       pkt_done,
	output logic       cmd_push,
	output cmd_t       cmd,
	output buf_wr_t    buf_wr
);

	typedef enum logic [1:0] {
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	phase_t           phase_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic             wbank_q;
	logic [1:0]       pkt_cnt_q;
	logic             accept;
	logic             commit;
	logic [LEN_W-1:0] idx_nx;

	// Hold off while both buffer banks are owned or the queue is full
	assign full   = cmd_full || (pkt_cnt_q == 2'd2);
	assign accept = push && !full;
	assign commit = accept && (phase_q == PH_SUM) && (rx_byte == sum_q);
	assign idx_nx = idx_q + 1'b1;

	// Decode the byte against the parse position
	always_comb begin
		cmd_push = 1'b0;
		cmd      = '0;
		buf_wr   = '0;
		if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					if (rx_byte == 8'd0) begin
						cmd_push = 1'b1;
						cmd.hdr  = 1'b1;
					end
				end
				PH_DATA: begin
					buf_wr.we   = 1'b1;
					buf_wr.bank = wbank_q;
					buf_wr.idx  = idx_q;
					buf_wr.data = rx_byte;
				end
				PH_SUM: begin
					if (commit) begin
						cmd_push = 1'b1;
						cmd.len  = len_q;
					end
				end
				default: begin
					cmd_push = 1'b0;
				end
			endcase
		end
	end

	// Advance the parse state, bank and outstanding packet count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN;
			len_q     <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			wbank_q   <= 1'b0;
			pkt_cnt_q <= '0;
		end else begin
			if (accept) begin
				unique case (phase_q)
					PH_LEN: begin
						if (rx_byte != 8'd0 && rx_byte <= 8'(MAX_PACKET)) begin
							len_q   <= rx_byte[LEN_W-1:0];
							idx_q   <= '0;
							sum_q   <= '0;
							phase_q <= PH_DATA;
						end
					end
					PH_DATA: begin
						sum_q <= sum_q + rx_byte;
						idx_q <= idx_nx;
						if (idx_nx >= len_q) begin
							phase_q <= PH_SUM;
						end
					end
					PH_SUM: begin
						phase_q <= PH_LEN;
					end
					default: begin
						phase_q <= PH_LEN;
					end
				endcase
			end
			if (commit) begin
				wbank_q <= !wbank_q;
			end
			case ({commit, pkt_done})
				2'b10:   pkt_cnt_q <= pkt_cnt_q + 1'b1;
				2'b01:   pkt_cnt_q <= pkt_cnt_q - 1'b1;
				default: pkt_cnt_q <= pkt_cnt_q;
			endcase
		end
	end

endmodule

/* sv/fplc_back.sv */
// ----------------------------------------------------------------------------
// fplc_back
// Executor: runs the CRC over each accepted packet, packs flash words,
// checks the flash limit and emits header, payload and overflow word requests.
// ----------------------------------------------------------------------------
module fplc_back import fplc_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        pkt_done,
	input  buf_wr_t     buf_wr,
	input  logic        out_full,
	output logic        out_push,
	output result_t     out_res,
	input  logic        cfg_wen,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic [31:0] header_base,
	input  logic [31:0] flash_limit
);

	localparam int IW        = $clog2(MAX_PACKET);
	localparam int BUF_DEPTH = 2 ** (IW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_RD,
		ST_PROC
	} state_t;

	logic [7:0]       buf_mem [BUF_DEPTH];
	logic [7:0]       rdata_q;

	state_t           state_q;
	logic             halted_q;
	logic             rbank_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] k_q;
	logic [2:0]       hcnt_q;
	logic [31:0]      crc_q;
	logic [31:0]      size_q;
	logic [31:0]      waddr_q;
	logic [31:0]      word_q;

	logic [31:0]      crc_n;
	logic [31:0]      word_n;
	logic [1:0]       lane;
	logic             last_byte;
	logic             word_end;
	logic             overflow;
	logic             rd_en;

	// Packet buffer: two banks, write from the parser, registered read here
	always_ff @(posedge clk) begin
		if (buf_wr.we) begin
			buf_mem[{buf_wr.bank, buf_wr.idx[IW-1:0]}] <= buf_wr.data;
		end
		if (rd_en) begin
			rdata_q <= buf_mem[{rbank_q, k_q[IW-1:0]}];
		end
	end

	assign rd_en     = (state_q == ST_RD);
	assign lane      = k_q[1:0];
	assign crc_n     = crc_byte(crc_q, rdata_q);
	assign last_byte = ((k_q + 1'b1) == len_q);
	assign word_end  = (lane == 2'd3) || last_byte;
	assign overflow  = (waddr_q >= flash_limit);
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;

	// Merge the byte into the word, padding fresh words with 0xFF
	always_comb begin
		word_n = (lane == 2'd0) ? CRC_INIT : word_q;
		word_n[8*lane +: 8] = rdata_q;
	end

	// Drive result requests and packet release
	always_comb begin
		out_push = 1'b0;
		out_res  = '0;
		pkt_done = cmd_pop && halted_q && !cmd.hdr;
		unique case (state_q)
			ST_HDR: begin
				out_push      = !out_full;
				out_res.kind  = KIND_HEADER;
				out_res.addr  = header_base + {27'd0, hcnt_q, 2'b00};
				out_res.value = hdr_word(hcnt_q, size_q, crc_q);
				out_res.last  = (hcnt_q == HDR_LAST_WORD);
			end
			ST_PROC: begin
				if (word_end && !out_full) begin
					out_push     = 1'b1;
					out_res.addr = waddr_q;
					if (overflow) begin
						out_res.kind  = KIND_OVERFLOW;
						out_res.value = '0;
						out_res.last  = 1'b1;
						pkt_done      = 1'b1;
					end else begin
						out_res.kind  = KIND_PAYLOAD;
						out_res.value = word_n;
						out_res.last  = last_byte;
						pkt_done      = last_byte;
					end
				end
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	// Sequence commands: header burst, or read-then-fold per payload byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			halted_q <= 1'b0;
			rbank_q  <= 1'b0;
			len_q    <= '0;
			k_q      <= '0;
			hcnt_q   <= '0;
			crc_q    <= CRC_INIT;
			size_q   <= '0;
			waddr_q  <= HEADER_BASE_RST + PAYLOAD_OFFSET;
			word_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && !halted_q) begin
						if (cmd.hdr) begin
							hcnt_q  <= '0;
							state_q <= ST_HDR;
						end else begin
							len_q   <= cmd.len;
							k_q     <= '0;
							size_q  <= size_q + 32'(cmd.len);
							state_q <= ST_RD;
						end
					end
				end
				ST_HDR: begin
					if (!out_full) begin
						hcnt_q <= hcnt_q + 1'b1;
						if (hcnt_q == HDR_LAST_WORD) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					if (!word_end) begin
						crc_q   <= crc_n;
						word_q  <= word_n;
						k_q     <= k_q + 1'b1;
						state_q <= ST_RD;
					end else if (!out_full) begin
						if (overflow) begin
							halted_q <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							crc_q   <= crc_n;
							word_q  <= word_n;
							waddr_q <= waddr_q + 32'd4;
							k_q     <= k_q + 1'b1;
							state_q <= last_byte ? ST_IDLE : ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (pkt_done) begin
				rbank_q <= !rbank_q;
			end
			// Reload the payload address on a header base write
			if (cfg_wen && cfg_idx == REG_HEADER_BASE) begin
				waddr_q <= cfg_wdata + PAYLOAD_OFFSET;
			end
		end
	end

endmodule

/* sv/firmware_packet_loader_crc32.sv */
// Path: a zero length byte queues a header command that the executor sends word by word;
// after the checksum byte the executor reads the packet bytes back and packs them into words.
// Throughput: the parser takes one byte per cycle until both buffer banks are owned or
// the command queue is full; the executor reads then folds each payload byte in turn.
// Reset: arst_n clears all control state asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
// firmware_packet_loader_crc32
// Firmware image loader: parses framed packets, keeps a running CRC-32 and
// image size, and emits flash word programming requests.
// ----------------------------------------------------------------------------
module firmware_packet_loader_crc32 import fplc_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [31:0] word_address,
	output logic [31:0] word_value,
	output logic        last_of_run,
	input  logic        cfg_wen,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] header_base_q;
	logic [31:0] flash_limit_q;

	logic        cmd_push;
	cmd_t        cmd_w;
	logic        cmd_full;
	logic        cmd_pop;
	logic        cmd_empty;
	cmd_t        cmd_r;
	logic        pkt_done;
	buf_wr_t     buf_wr;
	logic        out_push;
	logic        out_full;
	result_t     out_w;
	result_t     out_r;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_base_q <= HEADER_BASE_RST;
			flash_limit_q <= FLASH_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_HEADER_BASE: header_base_q <= cfg_wdata;
				default:         flash_limit_q <= cfg_wdata;
			endcase
		end
	end

	fplc_front #(
		.MAX_PACKET (MAX_PACKET)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.full     (full),
		.cmd_full (cmd_full),
		.pkt_done (pkt_done),
		.cmd_push (cmd_push),
		.cmd      (cmd_w),
		.buf_wr   (buf_wr)
	);

	fplc_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_w),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_r),
		.empty  (cmd_empty)
	);

	fplc_back #(
		.MAX_PACKET (MAX_PACKET)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_r),
		.cmd_pop     (cmd_pop),
		.pkt_done    (pkt_done),
		.buf_wr      (buf_wr),
		.out_full    (out_full),
		.out_push    (out_push),
		.out_res     (out_w),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.header_base (header_base_q),
		.flash_limit (flash_limit_q)
	);

	fplc_fifo #(
		.W     ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_w),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_r),
		.empty  (empty)
	);

	assign result_kind  = out_r.kind;
	assign word_address = out_r.addr;
	assign word_value   = out_r.value;
	assign last_of_run  = out_r.last;

endmodule

/* tb/fplc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplc_checker
// Watches the byte, result and register ports of the firmware packet loader.
// Keeps its own packet parser, CRC-32 and flash address state. Predicts every
// flash write request and compares each popped result against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module fplc_checker import fplc_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  result_kind,
	input  logic [31:0] word_address,
	input  logic [31:0] word_value,
	input  logic        last_of_run,
	input  logic        cfg_wen,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata,
	output int          fail_count,
	output int          outstanding,
	output int          rx_count,
	output int          payload_count,
	output int          header_count,
	output int          overflow_count,
	output int          reject_count
);

	typedef enum logic [1:0] {
		PH_LENGTH   = 2'd0,
		PH_PAYLOAD  = 2'd1,
		PH_CHECKSUM = 2'd2,
		PH_HALTED   = 2'd3
	} parse_phase_e;

	// Register copies
	logic [31:0] header_base;
	logic [31:0] flash_limit;

	// Parser and image state
	parse_phase_e phase;
	logic [6:0]   pkt_len;
	logic [6:0]   pkt_idx;
	logic [7:0]   pkt_sum;
	logic [7:0]   pkt_buf [0:MAX_PACKET-1];
	logic [31:0]  image_crc;
	logic [31:0]  image_bytes;
	logic [31:0]  next_addr;

	// Flash write requests still to be seen on the result side
	result_t flash_writes_due[$];

	// Advance a reflected CRC-32 by one byte, LSB first
	function automatic logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ d[k]) begin
				r = {1'b0, r[31:1]} ^ CRC_POLY;
			end else begin
				r = {1'b0, r[31:1]};
			end
		end
		return r;
	endfunction

	task automatic queue_write(input logic [1:0] kind, input logic [31:0] addr,
			input logic [31:0] value, input logic last);
		result_t w;
		w.kind  = kind;
		w.addr  = addr;
		w.value = value;
		w.last  = last;
		flash_writes_due.push_back(w);
	endtask

	// Work out the write requests that one received byte causes
	task automatic predict_rx_byte(input logic [7:0] b);
		logic [31:0] hdr [0:4];
		logic [31:0] w;
		logic        stop;
		int          i;
		int          j;
		case (phase)
			PH_LENGTH: begin
				if (b == 8'd0) begin
					hdr[0] = HDR_MAGIC;
					hdr[1] = image_bytes;
					hdr[2] = image_crc ^ CRC_INIT;
					hdr[3] = HDR_VERSION;
					hdr[4] = HDR_STATE_OK;
					for (i = 0; i < 5; i++) begin
						queue_write(KIND_HEADER, header_base + 4 * i, hdr[i], i == 4);
					end
				end else if (b <= MAX_PACKET) begin
					pkt_len = b[6:0];
					pkt_idx = '0;
					pkt_sum = '0;
					phase   = PH_PAYLOAD;
				end else begin
					reject_count++;
				end
			end
			PH_PAYLOAD: begin
				pkt_buf[pkt_idx] = b;
				pkt_sum = pkt_sum + b;
				pkt_idx = pkt_idx + 7'd1;
				if (pkt_idx >= pkt_len) begin
					phase = PH_CHECKSUM;
				end
			end
			PH_CHECKSUM: begin
				phase = PH_LENGTH;
				if (b != pkt_sum) begin
					reject_count++;
				end else begin
					for (i = 0; i < pkt_len; i++) begin
						image_crc = crc32_advance(image_crc, pkt_buf[i]);
					end
					image_bytes = image_bytes + pkt_len;
					stop = 1'b0;
					for (i = 0; i < pkt_len && !stop; i += 4) begin
						// Halt on the first word that would land past usable flash
						if (next_addr >= flash_limit) begin
							queue_write(KIND_OVERFLOW, next_addr, '0, 1'b1);
							phase = PH_HALTED;
							stop  = 1'b1;
						end else begin
							w = '1;
							for (j = 0; j < 4 && i + j < pkt_len; j++) begin
								w[8*j +: 8] = pkt_buf[i + j];
							end
							queue_write(KIND_PAYLOAD, next_addr, w, i + 4 >= pkt_len);
							next_addr = next_addr + 32'd4;
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result();
		result_t want;
		if (flash_writes_due.size() == 0) begin
			fail_count++;
			$error("unexpected result: kind %0d address %h value %h last %0d",
				result_kind, word_address, word_value, last_of_run);
		end else begin
			want = flash_writes_due.pop_front();
			case (want.kind)
				KIND_PAYLOAD:  payload_count++;
				KIND_HEADER:   header_count++;
				default:       overflow_count++;
			endcase
			if (result_kind !== want.kind) begin
				fail_count++;
				$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
			end
			if (word_address !== want.addr) begin
				fail_count++;
				$error("word_address: expected %h, got %h", want.addr, word_address);
			end
			if (word_value !== want.value) begin
				fail_count++;
				$error("word_value: expected %h, got %h", want.value, word_value);
			end
			if (last_of_run !== want.last) begin
				fail_count++;
				$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
			end
		end
	endtask

	// Track register writes, accepted bytes and popped results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_base    = HEADER_BASE_RST;
			flash_limit    = FLASH_LIMIT_RST;
			phase          = PH_LENGTH;
			pkt_len        = '0;
			pkt_idx        = '0;
			pkt_sum        = '0;
			image_crc      = CRC_INIT;
			image_bytes    = '0;
			next_addr      = HEADER_BASE_RST + PAYLOAD_OFFSET;
			flash_writes_due.delete();
			fail_count     = 0;
			rx_count       = 0;
			payload_count  = 0;
			header_count   = 0;
			overflow_count = 0;
			reject_count   = 0;
			outstanding   <= 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_idx == REG_HEADER_BASE) begin
					header_base = cfg_wdata;
					next_addr   = cfg_wdata + PAYLOAD_OFFSET;
				end else begin
					flash_limit = cfg_wdata;
				end
			end
			if (push && !full) begin
				rx_count++;
				predict_rx_byte(rx_byte);
			end
			if (pop && !empty) begin
				check_result();
			end
			outstanding <= flash_writes_due.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives framed packets into the firmware packet loader across several
// register settings and idle patterns, including a long result-side stall and
// a final address overflow halt. The checker beside the loader predicts and
// compares every flash write request.
// ----------------------------------------------------------------------------
module tb_top;
	import fplc_pkg::*;

	localparam int SETTLE_CYCLES  = 400;
	localparam int STALL_CYCLES   = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  result_kind;
	logic [31:0] word_address;
	logic [31:0] word_value;
	logic        last_of_run;
	logic        cfg_wen;
	logic        cfg_idx;
	logic [31:0] cfg_wdata;

	int fail_count;
	int outstanding;
	int rx_count;
	int payload_count;
	int header_count;
	int overflow_count;
	int reject_count;

	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       stall_go      = 1'b0;
	int         bytes_sent    = 0;
	int         quiet_cycles  = 0;
	logic [7:0] pkt_bytes [0:63];

	firmware_packet_loader_crc32 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.word_address (word_address),
		.word_value   (word_value),
		.last_of_run  (last_of_run),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	fplc_checker u_flash_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.empty          (empty),
		.pop            (pop),
		.result_kind    (result_kind),
		.word_address   (word_address),
		.word_value     (word_value),
		.last_of_run    (last_of_run),
		.cfg_wen        (cfg_wen),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.rx_count       (rx_count),
		.payload_count  (payload_count),
		.header_count   (header_count),
		.overflow_count (overflow_count),
		.reject_count   (reject_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort when no request moves on either side for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Pop results at random, with one long hold-off when asked
	initial begin : result_side
		logic stall_done;
		stall_done = 1'b0;
		pop <= 1'b0;
		@(posedge clk);
		forever begin
			if (stall_go && !stall_done) begin
				pop <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_done = 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Offer one byte and hold it until accepted; push stays high for the next one
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic stop_sending();
		push <= 1'b0;
	endtask

	// Send length, payload from pkt_bytes, then the checksum (optionally spoiled)
	task automatic send_packet(input int len, input bit corrupt);
		logic [7:0] len_byte;
		logic [7:0] sum;
		len_byte = 8'(len);
		sum = '0;
		send_byte(len_byte);
		for (int i = 0; i < len; i++) begin
			send_byte(pkt_bytes[i]);
			sum = sum + pkt_bytes[i];
		end
		if (corrupt) begin
			sum = sum + 8'($urandom_range(255, 1));
		end
		send_byte(sum);
	endtask

	task automatic fill_random(input int len);
		for (int i = 0; i < len; i++) begin
			pkt_bytes[i] = 8'($urandom_range(255));
		end
	endtask

	// Mostly well-formed packets; some headers, oversized lengths, bad checksums
	task automatic send_random(input int count);
		int target;
		int pick;
		int len;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 7) begin
				send_byte(8'h00);
			end else if (pick < 12) begin
				send_byte(8'($urandom_range(255, MAX_PACKET_DEF + 1)));
			end else begin
				len = (pick < 17) ? $urandom_range(MAX_PACKET_DEF, 32) : $urandom_range(12, 1);
				fill_random(len);
				send_packet(len, $urandom_range(99) < 10);
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every predicted request has popped, then let the loader go quiet
	task automatic drain_results();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		push      <= 1'b0;
		rx_byte   <= '0;
		cfg_wen   <= 1'b0;
		cfg_idx   <= REG_HEADER_BASE;
		cfg_wdata <= '0;
		send_idle_pct = 19;
		recv_idle_pct = 62;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Header base at the top of the address space so header and payload wrap
		write_reg(REG_HEADER_BASE, 32'hFFFF_FFFC);
		write_reg(REG_FLASH_LIMIT, 32'hFFFF_FFFF);

		// Header of an empty image
		send_byte(8'h00);
		// Oversized lengths are dropped
		send_byte(8'hFF);
		send_byte(8'(MAX_PACKET_DEF + 1));
		// Single byte packet, one padded word
		pkt_bytes[0] = 8'hFF;
		send_packet(1, 1'b0);
		// Checksum mismatch leaves no trace
		pkt_bytes[0] = 8'h00;
		pkt_bytes[1] = 8'h80;
		pkt_bytes[2] = 8'h7F;
		pkt_bytes[3] = 8'h01;
		send_packet(4, 1'b1);
		// Five bytes: a full word and a padded one
		pkt_bytes[0] = 8'h12;
		pkt_bytes[1] = 8'h34;
		pkt_bytes[2] = 8'h56;
		pkt_bytes[3] = 8'h78;
		pkt_bytes[4] = 8'h9A;
		send_packet(5, 1'b0);
		// All-zero payload with a zero checksum
		pkt_bytes[0] = 8'h00;
		pkt_bytes[1] = 8'h00;
		pkt_bytes[2] = 8'h00;
		send_packet(3, 1'b0);
		// Header after real data
		send_byte(8'h00);

		send_random(60);
		stop_sending();
		drain_results();

		// Swap idle patterns; header at address zero
		send_idle_pct = 62;
		recv_idle_pct = 19;
		write_reg(REG_HEADER_BASE, 32'h0000_0000);
		write_reg(REG_FLASH_LIMIT, 32'h0010_0000);
		send_random(60);
		stop_sending();
		drain_results();

		// No idling; reset values; stall the result side while full packets pour in
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_HEADER_BASE, HEADER_BASE_RST);
		write_reg(REG_FLASH_LIMIT, FLASH_LIMIT_RST);
		stall_go <= 1'b1;
		for (int p = 0; p < 2; p++) begin
			fill_random(MAX_PACKET_DEF);
			send_packet(MAX_PACKET_DEF, 1'b0);
		end
		send_random(50);
		stop_sending();
		drain_results();

		// Zero flash limit: headers still go out, a bad packet does nothing
		write_reg(REG_HEADER_BASE, 32'h0000_1000);
		write_reg(REG_FLASH_LIMIT, 32'h0000_0000);
		send_byte(8'h00);
		pkt_bytes[0] = 8'hA5;
		pkt_bytes[1] = 8'h5A;
		send_packet(2, 1'b1);
		stop_sending();
		drain_results();

		// Limit two words past the payload start: overflow mid-packet, then halt
		write_reg(REG_FLASH_LIMIT, 32'h0000_101C);
		fill_random(16);
		send_packet(16, 1'b0);
		send_byte(8'h00);
		pkt_bytes[0] = 8'h01;
		pkt_bytes[1] = 8'h02;
		pkt_bytes[2] = 8'h03;
		send_packet(3, 1'b0);
		stop_sending();
		drain_results();

		$display("Covered %0d bytes over five register settings and three idle patterns,",
			rx_count);
		$display("  %0d payload words, %0d header words, %0d overflow halts, %0d rejects",
			payload_count, header_count, overflow_count, reject_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
sv/fplc_pkg.sv
sv/fplc_fifo.sv
sv/fplc_front.sv
sv/fplc_back.sv
sv/firmware_packet_loader_crc32.sv
tb/fplc_checker.sv
tb/tb_top.sv
